/* hw/rtl/mlr_pkg.sv */
// Shared widths, codes and word types of the midpoint line rasterizer.
package mlr_pkg;

    // Width of one pixel coordinate.
    localparam int COORD_BITS = 12;
    // Octant-0 coordinates need one more bit, since negating the most
    // negative coordinate must still fit.
    localparam int WALK_BITS  = COORD_BITS + 1;
    // The decision value and its increments reach twice the largest span.
    localparam int DEC_BITS   = COORD_BITS + 4;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [WALK_BITS-1:0]  walk_t;
    typedef logic signed [DEC_BITS-1:0]   dec_t;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_TICK = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        OCT0 = 3'd0,
        OCT1 = 3'd1,
        OCT2 = 3'd2,
        OCT3 = 3'd3,
        OCT4 = 3'd4,
        OCT5 = 3'd5,
        OCT6 = 3'd6,
        OCT7 = 3'd7
    } octant_t;

    typedef struct packed {
        walk_t x;
        walk_t y;
    } point_t;

    typedef struct packed {
        walk_t   walk_x;
        walk_t   walk_y;
        walk_t   stop_x;
        octant_t octant;
        dec_t    decision;
        dec_t    east_step;
        dec_t    diag_step;
        logic    busy;
    } line_state_t;

    typedef struct packed {
        kind_t  kind;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } in_word_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   last_pixel;
    } out_word_t;

endpackage

/* hw/rtl/mlr_setup.sv */
// Line setup: octant classification, mapping into octant 0 and decision terms.
module mlr_setup import mlr_pkg::*; (
    input  in_word_t    load_word,
    output line_state_t line_state,
    output out_word_t   first_word
);

    localparam int DEC_EXT = DEC_BITS - WALK_BITS;

    function automatic point_t to_zero(octant_t z, walk_t x, walk_t y);
        point_t p;
        case (z)
            OCT0: begin p.x = x;  p.y = y;  end
            OCT1: begin p.x = y;  p.y = x;  end
            OCT2: begin p.x = y;  p.y = -x; end
            OCT3: begin p.x = -x; p.y = y;  end
            OCT4: begin p.x = -x; p.y = -y; end
            OCT5: begin p.x = -y; p.y = -x; end
            OCT6: begin p.x = -y; p.y = x;  end
            default: begin p.x = x; p.y = -y; end
        endcase
        return p;
    endfunction

    walk_t   sx, sy, ex, ey;
    walk_t   dx, dy, adx, ady;
    logic    wide;
    octant_t octant;
    point_t  start_p, stop_p;
    walk_t   mdx, mdy;
    dec_t    mdx_w, mdy_w;

    always_comb begin
        sx = {load_word.start_x[COORD_BITS-1], load_word.start_x};
        sy = {load_word.start_y[COORD_BITS-1], load_word.start_y};
        ex = {load_word.end_x[COORD_BITS-1], load_word.end_x};
        ey = {load_word.end_y[COORD_BITS-1], load_word.end_y};
        dx = ex - sx;
        dy = ey - sy;
        adx = dx[WALK_BITS-1] ? -dx : dx;
        ady = dy[WALK_BITS-1] ? -dy : dy;
        wide = adx > ady;

        case ({dx[WALK_BITS-1], dy[WALK_BITS-1]})
            2'b00:   octant = wide ? OCT0 : OCT1;
            2'b01:   octant = wide ? OCT7 : OCT6;
            2'b11:   octant = wide ? OCT4 : OCT5;
            default: octant = wide ? OCT3 : OCT2;
        endcase

        start_p = to_zero(octant, sx, sy);
        stop_p  = to_zero(octant, ex, ey);
        mdx = stop_p.x - start_p.x;
        mdy = stop_p.y - start_p.y;
        mdx_w = {{DEC_EXT{mdx[WALK_BITS-1]}}, mdx};
        mdy_w = {{DEC_EXT{mdy[WALK_BITS-1]}}, mdy};

        line_state.walk_x    = start_p.x;
        line_state.walk_y    = start_p.y;
        line_state.stop_x    = stop_p.x;
        line_state.octant    = octant;
        line_state.decision  = (mdy_w <<< 1) - mdx_w;
        line_state.east_step = mdy_w <<< 1;
        line_state.diag_step = (mdy_w - mdx_w) <<< 1;
        line_state.busy      = start_p.x < stop_p.x;

        first_word.pixel_x    = load_word.start_x;
        first_word.pixel_y    = load_word.start_y;
        first_word.last_pixel = ~line_state.busy;
    end

endmodule

/* hw/rtl/mlr_step.sv */
// One midpoint step in octant-0 space and the mapping back to the line's octant.
module mlr_step import mlr_pkg::*; (
    input  line_state_t cur_state,
    output line_state_t new_state,
    output out_word_t   pixel_word
);

    walk_t nx, ny, px, py;

    always_comb begin
        new_state = cur_state;
        nx = cur_state.walk_x + walk_t'(1);
        ny = cur_state.walk_y;
        if (cur_state.decision[DEC_BITS-1]) begin
            new_state.decision = cur_state.decision + cur_state.east_step;
        end else begin
            ny = cur_state.walk_y + walk_t'(1);
            new_state.decision = cur_state.decision + cur_state.diag_step;
        end
        new_state.walk_x = nx;
        new_state.walk_y = ny;
        new_state.busy   = nx < cur_state.stop_x;

        case (cur_state.octant)
            OCT0: begin px = nx;  py = ny;  end
            OCT1: begin px = ny;  py = nx;  end
            OCT2: begin px = -ny; py = nx;  end
            OCT3: begin px = -nx; py = ny;  end
            OCT4: begin px = -nx; py = -ny; end
            OCT5: begin px = -ny; py = -nx; end
            OCT6: begin px = ny;  py = -nx; end
            default: begin px = nx; py = -ny; end
        endcase

        pixel_word.pixel_x    = px[COORD_BITS-1:0];
        pixel_word.pixel_y    = py[COORD_BITS-1:0];
        pixel_word.last_pixel = ~new_state.busy;
    end

endmodule

/* hw/rtl/midpoint_line_rasterizer_top.sv */
// Top level of the midpoint line rasterizer: input register, line state and result register.
//
//   Channel   Direction  Ports                        Word
//   s_        in         s_valid, s_ready, s_word     in_word_t  (load or tick)
//   m_        out        m_valid, m_ready, m_word     out_word_t (one pixel)
//
// An accepted word waits in the input register until the result side is free. It is then
// processed against the line state, and its pixel lands in the result register at the
// next edge, where m_valid rises with it; a tick with no active line yields no pixel.
// One word is accepted and one pixel produced every cycle while the result channel does
// not stall; the throughput is set by the update of the line state, which each tick needs.
// Reset (aresetn low at a clock edge) empties both registers and leaves no
// line active. A stalled result holds the result register, which holds the
// input register, which then drops s_ready.
module midpoint_line_rasterizer_top import mlr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    logic        in_valid_reg, in_valid_next;
    in_word_t    in_word_reg;
    line_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_word_reg, out_word_next;

    line_state_t load_state, tick_state;
    out_word_t   load_word, tick_word;
    logic        out_free;
    logic        advance;

    mlr_setup u_setup (
        .load_word  (in_word_reg),
        .line_state (load_state),
        .first_word (load_word)
    );

    mlr_step u_step (
        .cur_state  (state_reg),
        .new_state  (tick_state),
        .pixel_word (tick_word)
    );

    // The result register can take a new pixel when it is empty or is being
    // drained in this cycle.
    assign out_free = ~out_valid_reg | m_ready;
    // The word in the input register is processed when the result side is free.
    assign advance  = in_valid_reg & out_free;
    assign s_ready  = ~in_valid_reg | out_free;

    always_comb begin
        in_valid_next  = in_valid_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg & ~m_ready;
        out_word_next  = out_word_reg;

        if (s_ready) begin
            in_valid_next = s_valid;
        end

        if (advance) begin
            if (in_word_reg.kind == KIND_LOAD) begin
                // A load always emits its start pixel and replaces any line.
                state_next     = load_state;
                out_valid_next = 1'b1;
                out_word_next  = load_word;
            end else if (state_reg.busy) begin
                state_next     = tick_state;
                out_valid_next = 1'b1;
                out_word_next  = tick_word;
            end
            // A tick with no active line is dropped without a pixel.
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            in_word_reg <= s_word;
        end
        out_word_reg <= out_word_next;
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_word_reg;

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the midpoint line rasterizer with its own pixel predictor.
module tb_top;
    import mlr_pkg::*;

    // Clock and the one reset pulse at the start of the run.
    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    always #10 aclk = ~aclk;

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Channel signals. Every input has a known value from time zero.
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_word = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    midpoint_line_rasterizer_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    // Words waiting to be sent, and the pixels that the accepted words must produce.
    in_word_t  raster_cmds[$];
    out_word_t expected_pixels[$];
    int        mismatches = 0;

    // Shadow copy of the line state. It starts at zero, just as reset leaves the block.
    int      walk_x = 0;
    int      walk_y = 0;
    int      stop_x = 0;
    int      decision = 0;
    int      east_step = 0;
    int      diag_step = 0;
    octant_t octant = OCT0;
    bit      line_busy = 1'b0;

    // Fold a point of the given octant into octant 0, where 0 <= dy <= dx.
    function automatic void fold_in(input octant_t z, input int x, input int y,
                                    output int ox, output int oy);
        case (z)
            OCT0: begin ox = x;  oy = y;  end
            OCT1: begin ox = y;  oy = x;  end
            OCT2: begin ox = y;  oy = -x; end
            OCT3: begin ox = -x; oy = y;  end
            OCT4: begin ox = -x; oy = -y; end
            OCT5: begin ox = -y; oy = -x; end
            OCT6: begin ox = -y; oy = x;  end
            default: begin ox = x; oy = -y; end
        endcase
    endfunction

    // The inverse of fold_in: bring an octant-0 point back to the line's own octant.
    function automatic void unfold(input octant_t z, input int x, input int y,
                                   output int ox, output int oy);
        case (z)
            OCT0: begin ox = x;  oy = y;  end
            OCT1: begin ox = y;  oy = x;  end
            OCT2: begin ox = -y; oy = x;  end
            OCT3: begin ox = -x; oy = y;  end
            OCT4: begin ox = -x; oy = -y; end
            OCT5: begin ox = -y; oy = -x; end
            OCT6: begin ox = y;  oy = -x; end
            default: begin ox = x; oy = -y; end
        endcase
    endfunction

    // Advance the shadow line by one accepted word and queue the pixel it yields, if any.
    // A load always yields its start pixel. A tick yields the next pixel only while a
    // line is active, and is otherwise dropped without a trace.
    function automatic void trace_pixel(input in_word_t w);
        int        sx, sy, ex, ey, dx, dy, stop_y, span_x, span_y, px, py;
        bit        wide;
        bit        emit;
        out_word_t pix;
        emit = 1'b0;
        px = 0;
        py = 0;
        if (w.kind == KIND_LOAD) begin
            sx = w.start_x;
            sy = w.start_y;
            ex = w.end_x;
            ey = w.end_y;
            dx = ex - sx;
            dy = ey - sy;
            wide = ((dx < 0) ? -dx : dx) > ((dy < 0) ? -dy : dy);
            // A tie between |dx| and |dy| goes to the steep octant of each quadrant.
            if (dx >= 0 && dy >= 0)
                octant = wide ? OCT0 : OCT1;
            else if (dx >= 0)
                octant = wide ? OCT7 : OCT6;
            else if (dy < 0)
                octant = wide ? OCT4 : OCT5;
            else
                octant = wide ? OCT3 : OCT2;
            fold_in(octant, sx, sy, walk_x, walk_y);
            fold_in(octant, ex, ey, stop_x, stop_y);
            span_x = stop_x - walk_x;
            span_y = stop_y - walk_y;
            decision = 2 * span_y - span_x;
            east_step = 2 * span_y;
            diag_step = 2 * (span_y - span_x);
            line_busy = walk_x < stop_x;
            px = sx;
            py = sy;
            emit = 1'b1;
        end else if (line_busy) begin
            walk_x += 1;
            if (decision < 0) begin
                decision += east_step;
            end else begin
                walk_y += 1;
                decision += diag_step;
            end
            line_busy = walk_x < stop_x;
            unfold(octant, walk_x, walk_y, px, py);
            emit = 1'b1;
        end
        if (emit) begin
            pix.pixel_x = px[COORD_BITS-1:0];
            pix.pixel_y = py[COORD_BITS-1:0];
            pix.last_pixel = !line_busy;
            expected_pixels.push_back(pix);
        end
    endfunction

    // Idle lengths: mostly short, a few long. The calm flag flips now and then to give
    // stretches of back-to-back traffic with no idling at all.
    function automatic int idle_len(inout bit calm);
        int r;
        if ($urandom_range(0, 99) == 0)
            calm = !calm;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        else if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 2);
        else if (r < 97)
            return $urandom_range(3, 8);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s is %0d, predicted %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Driver: presents one word at a time and holds it until the block takes it.
    bit drv_calm = 1'b0;
    int send_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                trace_pixel(s_word);
            end
            // A new word goes out only when the slot is empty or the current word was just
            // taken, so valid is never lowered while a word is still waiting.
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (raster_cmds.size() > 0) begin
                    s_word <= raster_cmds.pop_front();
                    s_valid <= 1'b1;
                    send_gap = idle_len(drv_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every accepted pixel against the oldest prediction and throttles
    // the result channel with random stalls.
    bit        mon_calm = 1'b0;
    int        stall_left = 0;
    out_word_t want_pix;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected pixel x", m_word.pixel_x, 0);
                end else begin
                    want_pix = expected_pixels.pop_front();
                    if (m_word.pixel_x !== want_pix.pixel_x)
                        report_mismatch("pixel_x", m_word.pixel_x, want_pix.pixel_x);
                    if (m_word.pixel_y !== want_pix.pixel_y)
                        report_mismatch("pixel_y", m_word.pixel_y, want_pix.pixel_y);
                    if (m_word.last_pixel !== want_pix.last_pixel)
                        report_mismatch("last_pixel", m_word.last_pixel,
                                        want_pix.last_pixel);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 2) == 0)
                    stall_left = idle_len(mon_calm);
            end
        end
    end

    // Stimulus helpers.
    task automatic queue_load(input int sx, input int sy, input int ex, input int ey);
        logic [63:0] raw;
        in_word_t    w;
        raw = {$urandom, $urandom};
        w = raw[$bits(in_word_t)-1:0];
        w.kind = KIND_LOAD;
        w.start_x = sx[COORD_BITS-1:0];
        w.start_y = sy[COORD_BITS-1:0];
        w.end_x = ex[COORD_BITS-1:0];
        w.end_y = ey[COORD_BITS-1:0];
        raster_cmds.push_back(w);
    endtask

    // Ticks carry random coordinates, which the block must ignore.
    task automatic queue_ticks(input int n);
        logic [63:0] raw;
        in_word_t    w;
        repeat (n) begin
            raw = {$urandom, $urandom};
            w = raw[$bits(in_word_t)-1:0];
            w.kind = KIND_TICK;
            raster_cmds.push_back(w);
        end
    endtask

    // A signed offset between endpoints: mostly short lines, now and then a long one.
    function automatic int pick_span();
        int r, mag;
        r = $urandom_range(0, 99);
        if (r < 8)
            mag = 0;
        else if (r < 78)
            mag = $urandom_range(1, 12);
        else if (r < 97)
            mag = $urandom_range(13, 60);
        else
            mag = $urandom_range(61, 400);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // A start coordinate that keeps start + d inside the coordinate range.
    function automatic int place_start(input int d);
        int lo, hi;
        lo = (d < 0) ? -2048 - d : -2048;
        hi = (d > 0) ? 2047 - d : 2047;
        return lo + $urandom_range(0, hi - lo);
    endfunction

    // Build the whole stimulus, then wait for it to drain and give the verdict.
    initial begin : stimulus
        int counted, kind_pick, dx, dy, sx, sy, n_pix, n_ticks;
        counted = 0;

        // Directed part. A tick before any line has been loaded must be dropped.
        queue_ticks(1);
        // A single-point line at the coordinate extremes ends at once.
        queue_load(-2048, 2047, -2048, 2047);
        // Full-range diagonals, each cut short by the next load.
        queue_load(-2048, -2048, 2047, 2047);
        queue_ticks(2);
        queue_load(2047, -2048, -2048, 2047);
        queue_ticks(2);
        // One short line in each of octants 0 to 6, one tick each; each load drops the line before it.
        queue_load(0, 0, 5, 2);
        queue_ticks(1);
        queue_load(0, 0, 2, 5);
        queue_ticks(1);
        queue_load(0, 0, -2, 5);
        queue_ticks(1);
        queue_load(0, 0, -5, 2);
        queue_ticks(1);
        queue_load(0, 0, -5, -2);
        queue_ticks(1);
        queue_load(0, 0, -2, -5);
        queue_ticks(1);
        queue_load(0, 0, 2, -5);
        queue_ticks(1);
        // A one-step line run to its end, then a tick after the end pixel.
        queue_load(10, -10, 11, -11);
        queue_ticks(2);

        // Random part: mostly complete lines, some cut short by a new load, and some
        // noise with endpoints anywhere in the coordinate range.
        while (counted < 1550) begin
            kind_pick = $urandom_range(0, 99);
            if (kind_pick < 90) begin
                dx = pick_span();
                dy = pick_span();
                // Ties and axis-aligned lines sit on octant borders.
                case ($urandom_range(0, 9))
                    0: dy = $urandom_range(0, 1) ? -dx : dx;
                    1: dx = 0;
                    2: dy = 0;
                    default: ;
                endcase
                sx = place_start(dx);
                sy = place_start(dy);
            end else begin
                sx = $urandom_range(0, 4095) - 2048;
                sy = $urandom_range(0, 4095) - 2048;
                dx = $urandom_range(0, 4095) - 2048 - sx;
                dy = $urandom_range(0, 4095) - 2048 - sy;
            end
            n_pix = (((dx < 0) ? -dx : dx) > ((dy < 0) ? -dy : dy)) ?
                    ((dx < 0) ? -dx : dx) : ((dy < 0) ? -dy : dy);
            if (kind_pick < 78)
                n_ticks = n_pix + (($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
            else if (kind_pick < 90)
                n_ticks = (n_pix > 0) ? $urandom_range(0, n_pix - 1) : 0;
            else
                n_ticks = $urandom_range(0, 3);
            queue_load(sx, sy, sx + dx, sy + dy);
            queue_ticks(n_ticks);
            counted += 1 + ((n_ticks < n_pix) ? n_ticks : n_pix);
        end

        // Wait until every word has been taken and every predicted pixel has arrived,
        // then give a short settle time for the two-stage pipeline.
        while (raster_cmds.size() > 0 || s_valid || !aresetn)
            @(posedge aclk);
        while (expected_pixels.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog, well beyond the slowest legal run.
    initial begin
        #40000000;
        $display("FAILURE");
        $finish;
    end

endmodule
